// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the stack calculator.
// Depends on nothing; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== hw/rtl/rsc_pkg.sv =====
// Shared types, codes and constants of the stack calculator.
// Used by the channel interfaces, the divider and the top level.
package rsc_pkg;

  localparam int DATA_W              = 16;
  localparam int CMD_W               = 4;
  localparam int DEPTH_W             = 7;
  localparam int ERR_W               = 3;
  localparam int DIV_CNT_W           = $clog2(DATA_W);
  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam logic [CMD_W-1:0] CMD_NOP   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PRINT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SUB   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_MUL   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DIV   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MOD   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DUP   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd10;

  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_OVER    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_DIV0    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_ILLEGAL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_TOP,
    S_RD_SEC,
    S_EXEC,
    S_DIV,
    S_WB,
    S_WB2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hw/rtl/rsc_cmd_if.sv =====
// Command channel of the stack calculator: valid/ready plus opcode and immediate.
// Depends on rsc_pkg for the field widths.
interface rsc_cmd_if import rsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] immediate;

  modport source (output valid, output cmd, output immediate, input ready);
  modport sink   (input valid, input cmd, input immediate, output ready);
endinterface

// ===== hw/rtl/rsc_res_if.sv =====
// Result channel of the stack calculator: valid/ready plus one result per command.
// Depends on rsc_pkg for the field widths.
interface rsc_res_if import rsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               print_valid;
  logic [DATA_W-1:0]  print_value;
  logic [DEPTH_W-1:0] stack_depth;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output print_valid, output print_value,
                  output stack_depth, output error_code, input ready);
  modport sink   (input valid, input print_valid, input print_value,
                  input stack_depth, input error_code, output ready);
endinterface

// ===== hw/rtl/rpn_stack_calculator.sv =====
// Stack calculator: executes one 16-bit stack command per transfer on the
// command channel and returns exactly one result per command.
// Channels: command (cmd, immediate) in, result (print_valid, print_value,
// stack_depth, error_code) out, both valid/ready; a transfer happens when
// valid and ready are both high at a rising edge of clk.
// The stack lives in a single-port-write, single-port-read memory with a
// registered read. Each command reads the top and then the second entry,
// executes, writes back, and loads the result register.
// Swap takes two write-backs; div and mod wait for a bit-serial divider,
// which produces one quotient bit per cycle. The next command can be taken
// in the cycle after the result register is loaded.
// The result register holds a result until the receiver takes it; a new
// command is accepted meanwhile, and its result waits in the final state
// until the register is free.
// Reset (rst, synchronous) empties the stack; memory contents are not cleared.
// Errors leave the stack unchanged and report a code with print_valid low.
// Depends on rsc_pkg, rsc_cmd_if, rsc_res_if, rsc_divider, assert_macros.svh.
`include "assert_macros.svh"

module rpn_stack_calculator import rsc_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input logic        clk,
  input logic        rst,
  rsc_cmd_if.sink    command,
  rsc_res_if.source  result
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  state_t state;
  state_t state_next;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_m1;
  logic [SP_W-1:0]   sp_m2;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] imm_r;
  logic [DATA_W-1:0] a_r;

  logic [SP_W-1:0]   sp_new;
  logic [ERR_W-1:0]  err_r;
  logic              wr_en_r;
  logic [AW-1:0]     wr_addr_r;
  logic [DATA_W-1:0] wr_data_r;
  logic              swap_r;
  logic              pv_r;

  logic [ERR_W-1:0]    x_err;
  logic [SP_W-1:0]     x_sp;
  logic                x_we;
  logic [AW-1:0]       x_waddr;
  logic [DATA_W-1:0]   x_wdata;
  logic                x_swap;
  logic                x_pv;
  logic                x_div;
  logic [2*DATA_W-1:0] prod;

  logic                    out_load;
  logic                    o_valid;
  logic                    o_print_valid;
  logic [DATA_W-1:0]       o_print_value;
  logic [DEPTH_W-1:0]      o_depth;
  logic [ERR_W-1:0]        o_err;
  logic [SP_W+DEPTH_W-1:0] depth_ext;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rsc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sp_m1 = sp - SP_W'(1);
  assign sp_m2 = sp - SP_W'(2);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (command.valid) state_next = S_RD_TOP;
      S_RD_TOP: state_next = S_RD_SEC;
      S_RD_SEC: state_next = S_EXEC;
      S_EXEC:   state_next = x_div ? S_DIV : S_WB;
      S_DIV:    if (div_rsp.done) state_next = S_WB;
      S_WB:     state_next = swap_r ? S_WB2 : S_FIN;
      S_WB2:    state_next = S_FIN;
      S_FIN:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    command.ready = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = sp_m1[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = wr_addr_r;
    mem_wdata     = wr_data_r;
    out_load      = 1'b0;
    case (state)
      S_IDLE: command.ready = 1'b1;
      S_RD_TOP: mem_re = (sp != '0);
      S_RD_SEC: begin
        mem_re    = (sp >= SP_W'(2));
        mem_raddr = sp_m2[AW-1:0];
      end
      S_WB: mem_we = wr_en_r;
      S_WB2: begin
        mem_we    = 1'b1;
        mem_waddr = sp_m2[AW-1:0];
        mem_wdata = a_r;
      end
      S_FIN: out_load = !o_valid || result.ready;
      default: ;
    endcase
  end

  always_comb begin
    x_err   = ERR_OK;
    x_sp    = sp;
    x_we    = 1'b0;
    x_waddr = sp[AW-1:0];
    x_wdata = rd_data;
    x_swap  = 1'b0;
    x_pv    = 1'b0;
    x_div   = 1'b0;
    prod    = a_r * rd_data;
    case (cmd_r)
      CMD_NOP: ;
      CMD_PUSH: begin
        if (sp == SP_W'(STACK_DEPTH)) begin
          x_err = ERR_OVER;
        end else begin
          x_we    = 1'b1;
          x_wdata = imm_r;
          x_sp    = sp + SP_W'(1);
        end
      end
      CMD_POP, CMD_PRINT: begin
        if (sp == '0) begin
          x_err = ERR_UNDER;
        end else begin
          x_sp = sp_m1;
          x_pv = (cmd_r == CMD_PRINT);
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
        x_waddr = sp_m2[AW-1:0];
        if (sp < SP_W'(2)) begin
          x_err = ERR_UNDER;
        end else if ((cmd_r inside {CMD_DIV, CMD_MOD}) && a_r == '0) begin
          x_err = ERR_DIV0;
        end else begin
          x_we  = 1'b1;
          x_sp  = sp_m1;
          x_div = (cmd_r inside {CMD_DIV, CMD_MOD});
          case (cmd_r)
            CMD_ADD: x_wdata = a_r + rd_data;
            CMD_SUB: x_wdata = rd_data - a_r;
            CMD_MUL: x_wdata = prod[DATA_W-1:0];
            default: x_wdata = rd_data;
          endcase
        end
      end
      CMD_DUP: begin
        if (sp == '0) begin
          x_err = ERR_UNDER;
        end else if (sp == SP_W'(STACK_DEPTH)) begin
          x_err = ERR_OVER;
        end else begin
          x_we    = 1'b1;
          x_wdata = a_r;
          x_sp    = sp + SP_W'(1);
        end
      end
      CMD_SWAP: begin
        if (sp < SP_W'(2)) begin
          x_err = ERR_UNDER;
        end else begin
          x_we    = 1'b1;
          x_waddr = sp_m1[AW-1:0];
          x_wdata = rd_data;
          x_swap  = 1'b1;
        end
      end
      default: x_err = ERR_ILLEGAL;
    endcase
  end

  assign div_req.start    = (state == S_EXEC) && x_div;
  assign div_req.dividend = rd_data;
  assign div_req.divisor  = a_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        sp      <= sp_new;
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign depth_ext = {{DEPTH_W{1'b0}}, sp_new};

  always_ff @(posedge clk) begin
    if (command.valid && command.ready) begin
      cmd_r <= command.cmd;
      imm_r <= command.immediate;
    end
    if (state == S_RD_SEC) a_r <= rd_data;
    if (state == S_EXEC) begin
      err_r     <= x_err;
      sp_new    <= x_sp;
      wr_en_r   <= x_we;
      wr_addr_r <= x_waddr;
      wr_data_r <= x_wdata;
      swap_r    <= x_swap;
      pv_r      <= x_pv;
    end
    if (state == S_DIV && div_rsp.done) begin
      wr_data_r <= (cmd_r == CMD_DIV) ? div_rsp.quotient : div_rsp.remainder;
    end
    if (out_load) begin
      o_print_valid <= pv_r;
      o_print_value <= pv_r ? a_r : '0;
      o_depth       <= depth_ext[DEPTH_W-1:0];
      o_err         <= err_r;
    end
  end

  assign result.valid       = o_valid;
  assign result.print_valid = o_print_valid;
  assign result.print_value = o_print_value;
  assign result.stack_depth = o_depth;
  assign result.error_code  = o_err;

  `ASSERT_AT(a_sp_bound, clk, rst, sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `ASSERT_AT(a_err_no_write, clk, rst, mem_we |-> err_r == ERR_OK, "write on failed command")
  `ASSERT_AT(a_err_sp_hold, clk, rst, (out_load && err_r != ERR_OK) |=> $stable(sp), "error moved sp")
  `ASSERT_AT(a_accept_read, clk, rst, (command.valid && command.ready) |=> state == S_RD_TOP, "no read after transfer")

endmodule

// ===== hw/rtl/rsc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsc_divider import rsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dsr;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 ge;
  logic [DATA_W-1:0]    rem_next;
  logic [DATA_W-1:0]    quo_next;

  always_comb begin
    shifted  = {rem, quo[DATA_W-1]};
    diff     = shifted - {1'b0, dsr};
    ge       = shifted >= {1'b0, dsr};
    rem_next = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    quo_next = {quo[DATA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  `ASSERT_NEVER(a_start_busy, clk, rst, req.start && busy, "divider started while busy")
  `ASSERT_AT(a_done_pulse, clk, rst, done |=> !done, "divider done longer than one cycle")
  `ASSERT_AT(a_done_after_busy, clk, rst, done |-> $past(busy), "divider done without work")

endmodule
